@@ src/aeske_pkg.sv @@
// Package for the AES-128 key expansion block.
// Holds the key types, the AES S-box, the round constants and the round-count constants.
// Depends on nothing; every other file of the block imports it.
package aeske_pkg;

	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_W      = KEY_WORDS * WORD_W;
	localparam int unsigned HALF_W     = KEY_W / 2;
	localparam int unsigned ROUND_W    = 4;
	localparam int unsigned ROUND_KEYS = 11;

	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_KEYS - 1);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic [ROUND_W-1:0] round_t;
	typedef logic [7:0]        byte_t;

	// Standard FIPS-197 substitution table.
	localparam byte_t SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	// Round constant for the round key being formed; rounds outside 1 to 10 get zero.
	function automatic byte_t rcon(input round_t round);
		byte_t rc;
		unique case (round)
			4'd1:    rc = 8'h01;
			4'd2:    rc = 8'h02;
			4'd3:    rc = 8'h04;
			4'd4:    rc = 8'h08;
			4'd5:    rc = 8'h10;
			4'd6:    rc = 8'h20;
			4'd7:    rc = 8'h40;
			4'd8:    rc = 8'h80;
			4'd9:    rc = 8'h1b;
			4'd10:   rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

endpackage

@@ src/aeske_if.sv @@
// Handshake channels of the AES-128 key expansion block.
// One channel carries cipher keys in, the other carries round keys out.
// Depends on aeske_pkg for the field types.
interface aeske_key_if;
	import aeske_pkg::*;

	logic  valid;
	logic  ready;
	half_t key_high;
	half_t key_low;

	modport source (output valid, output key_high, output key_low, input ready);
	modport sink (input valid, input key_high, input key_low, output ready);
endinterface

interface aeske_rk_if;
	import aeske_pkg::*;

	logic   valid;
	logic   ready;
	round_t round_index;
	half_t  round_key_high;
	half_t  round_key_low;
	logic   last_round;

	modport source (output valid, output round_index, output round_key_high,
		output round_key_low, output last_round, input ready);
	modport sink (input valid, input round_index, input round_key_high,
		input round_key_low, input last_round, output ready);
endinterface

@@ src/aeske_round.sv @@
// Shared round unit of the AES-128 key expansion block.
// Forms the next round key from the current one in one pass; used once per round.
// Depends on aeske_pkg for the S-box, round constants and key types.
module aeske_round (
	input  aeske_pkg::key_t   cur_key,
	input  aeske_pkg::round_t next_round,
	output aeske_pkg::key_t   next_key
);
	import aeske_pkg::*;

	word_t w0, w1, w2, w3;
	word_t rot_w;
	word_t sub_w;
	word_t temp_w;
	word_t n0, n1, n2, n3;

	assign w0 = cur_key[KEY_W-1 -: WORD_W];
	assign w1 = cur_key[KEY_W-WORD_W-1 -: WORD_W];
	assign w2 = cur_key[2*WORD_W-1 -: WORD_W];
	assign w3 = cur_key[WORD_W-1:0];

	assign rot_w = {w3[WORD_W-9:0], w3[WORD_W-1 -: 8]};

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			sub_w[8*b +: 8] = SBOX[rot_w[8*b +: 8]];
		end
	end

	assign temp_w = sub_w ^ {rcon(next_round), 24'h000000};

	// Each word chains off the one before it.
	assign n0 = w0 ^ temp_w;
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;

	assign next_key = {n0, n1, n2, n3};
endmodule

@@ src/aes128_key_expansion.sv @@
// Top level of the AES-128 key expansion block.
// Holds the round sequencer and output register around the shared round unit.
// Depends on aeske_pkg, aeske_if and aeske_round.
//
// This block takes one 128-bit AES cipher key per item, byte 0 in the top bits of key_high,
// and returns the eleven round keys of the AES-128 key schedule as eleven items in order,
// round 0 (the cipher key itself) through round 10, with last_round set on round 10. Each
// round key comes from the previous one through a single round unit (four S-box lookups
// and a chain of word XORs), so one round key is formed per cycle unless the result side
// stalls the output register. The key input is not ready while a key is being expanded;
// it becomes ready in the cycle the round 10 key is loaded, so the next key can be taken
// in the same cycle as the last round key of the previous one enters the output register.
// A full output register separates the two sides, so a stalled result holds its value and
// the next key can be accepted while the last round key still waits to be taken.
module aes128_key_expansion (
	input  logic           clk,
	input  logic           arst_n,
	aeske_key_if.sink      key,
	aeske_rk_if.source     round_key
);
	import aeske_pkg::*;

	// Sequencer state: busy while round keys of the current cipher key remain to be loaded into the output register.
	logic   busy_q;
	round_t round_q;
	key_t   key_q;
	key_t   next_key;

	// Output register.
	logic   out_valid_q;
	key_t   out_key_q;
	round_t out_index_q;
	logic   out_last_q;

	logic   accept_in;
	logic   load_out;
	logic   last_load;
	round_t next_round;

	// A round key moves to the output register whenever the register is free or being emptied.
	assign load_out   = busy_q && (!out_valid_q || round_key.ready);
	assign last_load  = load_out && (round_q == LAST_ROUND);
	assign key.ready  = !busy_q || last_load;
	assign accept_in  = key.valid && key.ready;
	assign next_round = round_q + round_t'(1);

	aeske_round u_round (
		.cur_key    (key_q),
		.next_round (next_round),
		.next_key   (next_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new key can arrive in the same cycle the previous one finishes.
			if (accept_in) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end else if (load_out) begin
				round_q <= next_round;
				if (last_load) begin
					busy_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (round_key.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Key and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			key_q <= {key.key_high, key.key_low};
		end else if (load_out) begin
			key_q <= next_key;
		end
		if (load_out) begin
			out_key_q   <= key_q;
			out_index_q <= round_q;
			out_last_q  <= (round_q == LAST_ROUND);
		end
	end

	assign round_key.valid          = out_valid_q;
	assign round_key.round_index    = out_index_q;
	assign round_key.round_key_high = out_key_q[KEY_W-1 -: HALF_W];
	assign round_key.round_key_low  = out_key_q[HALF_W-1:0];
	assign round_key.last_round     = out_last_q;
endmodule

@@ src/aeske_checker.sv @@
// Port checker for the AES-128 key expansion block, bound to the top level.
// Watches the key and round key channels over time.
// Depends on aeske_pkg and on the top level aes128_key_expansion.
module aeske_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              key_valid,
	input logic              key_ready,
	input logic              rk_valid,
	input logic              rk_ready,
	input aeske_pkg::round_t rk_index,
	input aeske_pkg::half_t  rk_high,
	input aeske_pkg::half_t  rk_low,
	input logic              rk_last
);
	import aeske_pkg::*;

	// A key just taken blocks the next one while it is expanded.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_ready |=> !key_ready)
		else $error("key input ready right after a key was accepted");

	// Round keys follow one another in order without a gap.
	a_round_order: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid && rk_ready && !rk_last |=>
		rk_valid && (rk_index == $past(rk_index) + round_t'(1)))
		else $error("round key sequence broken");

	// The last flag marks round 10 and nothing else.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid |-> (rk_last == (rk_index == LAST_ROUND)))
		else $error("last_round does not match round_index");

	// While an unfinished run is stalled on the result side, no key is taken.
	a_no_key_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid && !rk_last && !rk_ready |-> !key_ready)
		else $error("key input ready in the middle of a run");

	// A stalled round key holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rk_valid && !rk_ready |=>
		rk_valid && $stable(rk_index) && $stable(rk_high) && $stable(rk_low))
		else $error("stalled round key changed");
endmodule

bind aes128_key_expansion aeske_checker u_aeske_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.key_valid (key.valid),
	.key_ready (key.ready),
	.rk_valid  (round_key.valid),
	.rk_ready  (round_key.ready),
	.rk_index  (round_key.round_index),
	.rk_high   (round_key.round_key_high),
	.rk_low    (round_key.round_key_low),
	.rk_last   (round_key.last_round)
);
